/* hw/rtl/mwa_pkg.sv */
`timescale 1ns / 1ps

package mwa_pkg;

   // fixed field widths of the request, response and csr beats
   localparam int CHANNEL_BITS = 2;
   localparam int SAMPLE_FIELD_BITS = 16;
   localparam int AVERAGE_BITS = 16;
   localparam int WL_BITS = 5;

   localparam logic OP_STORE = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                         operation;
      logic [CHANNEL_BITS-1:0]      channel;
      logic [SAMPLE_FIELD_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [AVERAGE_BITS-1:0] average;
      logic                    ready_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_DONE
   } seq_state_type;

   // sequencer to datapath controls
   typedef struct packed {
      logic clear_acc;
      logic acc_add;
      logic div_step;
      logic load_rsp;
      logic rsp_ok;
   } seq_ctrl_type;

endpackage

/* hw/rtl/multichannel_window_average.sv */
`timescale 1ns / 1ps
// store beat: one per cycle while busy is low, no response, busy stays low
// read beat: SUM adds window_length slots, DIV divides by window_length, DONE loads the response
//   into the strobe register; next beat waits for IDLE; one shared adder walks then divides
// read of a channel that never filled: skips SUM and DIV, DONE loads a not-ready response
// reset clears control state, then a busy sweep zeroes all CHANNELS * WINDOW_DEPTH memory entries
// response is a one-cycle strobe and cannot be stalled by the receiver

module multichannel_window_average #(
   parameter int CHANNELS = 4,
   parameter int WINDOW_DEPTH = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         start,
   output logic                         busy,
   input  mwa_pkg::req_type             req_payload,
   // response channel
   output logic                         rsp_strobe,
   output mwa_pkg::rsp_type             rsp_payload,
   // window length register
   input  logic                         csr_write_enable,
   input  logic [mwa_pkg::WL_BITS-1:0]  csr_write_data
);

   import mwa_pkg::*;

   localparam int DEPTH = CHANNELS * WINDOW_DEPTH;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int WLW = $clog2(WINDOW_DEPTH + 1);
   localparam int SW = SAMPLE_BITS + WLW;

   // window length, held clamped to 1..WINDOW_DEPTH
   logic [WLW-1:0] wl_ff, wl_in;

   // per-channel write position and full flag
   logic [PW-1:0]  pos_ff [CHANNELS];
   logic [PW-1:0]  pos_in [CHANNELS];
   logic           full_ff [CHANNELS];
   logic           full_in [CHANNELS];

   // channel of the read in flight
   logic [CIW-1:0] ch_ff, ch_in;

   logic           accept;
   logic [CIW-1:0] ch_idx;
   logic           ch_ok;
   logic           store_go;
   logic           read_beat;
   logic           read_go;
   logic           read_nil;
   logic [PW:0]    pos_next;

   // sequencer hookup
   logic           seq_idle;
   logic           clearing;
   logic [AW-1:0]  clr_addr;
   logic [WLW-1:0] rd_idx;
   seq_ctrl_type   ctrl;

   // memory ports
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [SAMPLE_BITS-1:0] mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [SAMPLE_BITS-1:0] mem_rdata;

   assign busy = ~seq_idle;
   assign accept = start & ~busy;

   // channel numbers at or above CHANNELS are dropped on store and read as not ready
   assign ch_idx = CIW'(req_payload.channel);
   assign ch_ok = (32'(req_payload.channel) < CHANNELS);
   assign store_go = accept && (req_payload.operation == OP_STORE) && ch_ok;
   assign read_beat = accept && (req_payload.operation == OP_READ);
   assign read_go = read_beat && ch_ok && full_ff[ch_idx];
   assign read_nil = read_beat && !(ch_ok && full_ff[ch_idx]);

   // csr write with clamp
   always_comb begin
      wl_in = wl_ff;
      if (csr_write_enable) begin
         priority if (csr_write_data == '0) begin
            wl_in = WLW'(1);
         end else if (32'(csr_write_data) > WINDOW_DEPTH) begin
            wl_in = WLW'(WINDOW_DEPTH);
         end else begin
            wl_in = WLW'(csr_write_data);
         end
      end
   end

   // position advance; wrapping at the window length marks the channel full
   assign pos_next = (PW + 1)'(pos_ff[ch_idx]) + (PW + 1)'(1);

   always_comb begin
      pos_in = pos_ff;
      full_in = full_ff;
      if (store_go) begin
         if (32'(pos_next) >= 32'(wl_ff)) begin
            pos_in[ch_idx] = '0;
            full_in[ch_idx] = 1'b1;
         end else begin
            pos_in[ch_idx] = PW'(pos_next);
         end
      end
   end

   assign ch_in = read_go ? ch_idx : ch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WLW'(WINDOW_DEPTH);
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
            full_ff[c] <= 1'b0;
         end
      end else begin
         wl_ff <= wl_in;
         pos_ff <= pos_in;
         full_ff <= full_in;
      end
      ch_ff <= ch_in;
   end

   // memory: clear sweep after reset, otherwise store beats write
   always_comb begin
      if (clearing) begin
         mem_we = 1'b1;
         mem_waddr = clr_addr;
         mem_wdata = '0;
      end else begin
         mem_we = store_go;
         mem_waddr = AW'(32'(ch_idx) * WINDOW_DEPTH + 32'(pos_ff[ch_idx]));
         mem_wdata = SAMPLE_BITS'(req_payload.sample);
      end
   end

   // window walk of the read channel, slot 0 upward
   assign mem_raddr = AW'(32'(ch_ff) * WINDOW_DEPTH + 32'(rd_idx));

   mwa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mwa_seq #(
      .DEPTH (DEPTH),
      .WLW   (WLW),
      .SW    (SW)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .read_go  (read_go),
      .read_nil (read_nil),
      .wl       (wl_ff),
      .idle     (seq_idle),
      .clearing (clearing),
      .clr_addr (clr_addr),
      .rd_idx   (rd_idx),
      .ctrl     (ctrl)
   );

   mwa_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WLW         (WLW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .rdata       (mem_rdata),
      .wl          (wl_ff),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hw/rtl/mwa_ram.sv */
`timescale 1ns / 1ps

module mwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/mwa_seq.sv */
`timescale 1ns / 1ps

module mwa_seq #(
   parameter int DEPTH = 64,
   parameter int WLW = 5,
   parameter int SW = 21,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int DCW = $clog2(SW + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  read_go,
   input  logic                  read_nil,
   input  logic [WLW-1:0]        wl,
   output logic                  idle,
   output logic                  clearing,
   output logic [AW-1:0]         clr_addr,
   output logic [WLW-1:0]        rd_idx,
   output mwa_pkg::seq_ctrl_type ctrl
);

   import mwa_pkg::*;

   seq_state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [WLW-1:0] idx_ff, idx_in;
   logic           pend_ff, pend_in;
   logic           ok_ff, ok_in;
   logic [DCW-1:0] div_ff, div_in;
   logic           rd_en;
   logic           clr_last;
   logic           div_last;

   assign clr_last = (32'(clr_ff) == DEPTH - 1);
   assign div_last = (32'(div_ff) == SW - 1);
   assign rd_en = (state_ff == ST_SUM) && (idx_ff < wl);

   // status straight from the state register
   assign idle = (state_ff == ST_IDLE);
   assign clearing = (state_ff == ST_CLEAR);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            priority if (read_go) begin
               state_in = ST_SUM;
            end else if (read_nil) begin
               state_in = ST_DONE;
            end
         end
         ST_SUM: begin
            if (!rd_en && !pend_ff) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl = '0;
         end
         ST_IDLE: begin
            ctrl.clear_acc = read_go;
         end
         ST_SUM: begin
            ctrl.acc_add = pend_ff;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
         end
         ST_DONE: begin
            ctrl.load_rsp = 1'b1;
            ctrl.rsp_ok = ok_ff;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   // counters
   always_comb begin
      clr_in = clr_ff;
      idx_in = idx_ff;
      div_in = div_ff;
      ok_in = ok_ff;
      pend_in = rd_en;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + AW'(1);
      end
      if (state_ff == ST_IDLE) begin
         idx_in = '0;
         div_in = '0;
         if (read_go || read_nil) begin
            ok_in = read_go;
         end
      end
      if (rd_en) begin
         idx_in = idx_ff + WLW'(1);
      end
      if (state_ff == ST_DIV) begin
         div_in = div_ff + DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         idx_ff <= '0;
         pend_ff <= 1'b0;
         ok_ff <= 1'b0;
         div_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         idx_ff <= idx_in;
         pend_ff <= pend_in;
         ok_ff <= ok_in;
         div_ff <= div_in;
      end
   end

   assign clr_addr = clr_ff;
   assign rd_idx = idx_ff;

endmodule

/* hw/rtl/mwa_datapath.sv */
`timescale 1ns / 1ps

module mwa_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int WLW = 5,
   localparam int SW = SAMPLE_BITS + WLW,
   localparam int AUW = SW + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mwa_pkg::seq_ctrl_type  ctrl,
   input  logic [SAMPLE_BITS-1:0] rdata,
   input  logic [WLW-1:0]         wl,
   output logic                   rsp_strobe,
   output mwa_pkg::rsp_type       rsp_payload
);

   import mwa_pkg::*;

   logic [SW-1:0]  acc_ff, acc_in;
   logic [WLW-1:0] rem_ff, rem_in;
   logic           strobe_ff, strobe_in;
   rsp_type        rsp_ff, rsp_in;

   logic [WLW:0]   trial;
   logic [AUW-1:0] au_a;
   logic [AUW-1:0] au_b;
   logic           au_sub;
   logic [AUW-1:0] au_sum;
   logic           no_borrow;

   // restoring division: shift next dividend bit into the partial remainder
   assign trial = {rem_ff, acc_ff[SW-1]};

   // one shared add / subtract unit
   always_comb begin
      if (ctrl.div_step) begin
         au_a = AUW'(trial);
         au_b = AUW'(wl);
         au_sub = 1'b1;
      end else begin
         au_a = AUW'(acc_ff);
         au_b = AUW'(rdata);
         au_sub = 1'b0;
      end
   end

   assign au_sum = au_a + (au_sub ? ~au_b : au_b) + AUW'(au_sub);
   assign no_borrow = ~au_sum[AUW-1];

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      rsp_in = rsp_ff;
      strobe_in = ctrl.load_rsp;
      priority if (ctrl.clear_acc) begin
         acc_in = '0;
         rem_in = '0;
      end else if (ctrl.acc_add) begin
         acc_in = au_sum[SW-1:0];
      end else if (ctrl.div_step) begin
         acc_in = {acc_ff[SW-2:0], no_borrow};
         rem_in = no_borrow ? au_sum[WLW-1:0] : trial[WLW-1:0];
      end
      if (ctrl.load_rsp) begin
         rsp_in.average = ctrl.rsp_ok ? AVERAGE_BITS'(acc_ff) : '0;
         rsp_in.ready_res = ctrl.rsp_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
